// File: rtl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// shared types and constants of the linear probe hash set unit
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

  localparam int unsigned Capacity    = 1024;
  localparam int unsigned KeyBits     = 32;
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned SlotBits    = $clog2(Capacity);
  localparam int unsigned SizeBits    = 11;
  localparam int unsigned CountBits   = 11;
  localparam int unsigned HashBits    = 32;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindRemove = 2'd1,
    KindFind   = 2'd2,
    KindSpare  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MarkEmpty = 2'd0,
    MarkTomb  = 2'd1,
    MarkFull  = 2'd2,
    MarkSpare = 2'd3
  } mark_e;

  typedef enum logic [2:0] {
    StAdded   = 3'd0,
    StPresent = 3'd1,
    StFull    = 3'd2,
    StRemoved = 3'd3,
    StMissing = 3'd4,
    StFound   = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] payload;
    logic [31:0] key_hash;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] stored_payload;
    logic [9:0]  slot_index;
    logic [10:0] element_total;
  } rsp_t;

  // one slot entry as stored in the slot memory
  typedef struct packed {
    logic [1:0]             mark;
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] payload;
  } slot_t;

  // write request from the probe engine to the slot store
  typedef struct packed {
    logic                en;
    logic                mark_only;
    logic [SlotBits-1:0] addr;
    slot_t               data;
  } slot_wr_t;

endpackage

`default_nettype wire

// File: rtl/linear_probe_hash_set_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set_unit
// open-addressing hash set with linear probing and deletion tombstones
// ----------------------------------------------------------------------------
// sequence: the serial hash reduction, then a read and an evaluation per
//   probed slot; the last probe also writes back and registers the result word
// requests: one at a time, as the serial hash reduction and the single slot
//   memory read port stay busy until the result word is registered
// reset: a clearing pass marks every one of the 1024 slots empty; no request
//   word is taken during it, configuration writes are taken at any time
`default_nettype none

module linear_probe_hash_set_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // request channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire lphs_pkg::req_t                in_data,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output lphs_pkg::rsp_t                     out_data,
  // configuration channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lphs_pkg::SizeBits-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int unsigned SB = lphs_pkg::SlotBits;

  logic [2:0]                     state_q, state_d;
  logic [lphs_pkg::SizeBits-1:0]  size_q;
  logic [lphs_pkg::SizeBits-1:0]  eff_size;
  lphs_pkg::req_t                 req_q;
  logic [SB-1:0]                  pos_q, pos_d;
  logic [lphs_pkg::SizeBits-1:0]  cnt_q, cnt_d;  // slots probed so far
  logic [SB-1:0]                  tomb_q, tomb_d;
  logic                           tomb_seen_q, tomb_seen_d;
  logic [lphs_pkg::CountBits-1:0] occ_q, occ_d;
  logic                           out_valid_q, out_valid_d;
  lphs_pkg::rsp_t                 rsp_q, rsp_d;

  lphs_pkg::slot_wr_t             wr;
  lphs_pkg::slot_t                rd_data;
  logic [SB-1:0]                  rd_addr;
  logic                           clr_busy;
  logic                           mod_done;
  logic [SB-1:0]                  mod_rem;
  logic                           accept;
  logic [SB-1:0]                  pos_next;

  // effective table size: zero acts as one, clipped to capacity
  always_comb begin
    if (size_q == '0) eff_size = lphs_pkg::SizeBits'(1);
    else if (size_q > lphs_pkg::SizeBits'(lphs_pkg::Capacity))
      eff_size = lphs_pkg::SizeBits'(lphs_pkg::Capacity);
    else eff_size = size_q;
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != S_IDLE) || clr_busy;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_q;
  assign out_data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= lphs_pkg::SizeBits'(lphs_pkg::Capacity);
    else if (cfg_valid) size_q <= cfg_data;
  end

  lphs_hash_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .hash_i  (in_data.key_hash),
    .size_i  (eff_size),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign rd_addr = pos_q;

  lphs_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .wr_i       (wr),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  // wrap to slot zero at the end of the active table
  assign pos_next = ({1'b0, pos_q} + 1'b1 >= eff_size) ? '0 : pos_q + 1'b1;

  always_comb begin
    logic    match;
    logic    fin;
    logic    have;
    logic    hit;
    logic [SB-1:0] loc;
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    tomb_d      = tomb_q;
    tomb_seen_d = tomb_seen_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    wr          = '0;
    match       = 1'b0;
    fin         = 1'b0;
    have        = 1'b0;
    hit         = 1'b0;
    loc         = '0;

    if (out_valid_q && !out_stall) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d     = S_HASH;
          cnt_d       = '0;
          tomb_seen_d = 1'b0;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          pos_d   = mod_rem;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        match = (rd_data.mark == lphs_pkg::MarkFull) && (rd_data.key == req_q.key);
        if (rd_data.mark == lphs_pkg::MarkEmpty) begin
          fin  = 1'b1;
          have = 1'b1;
          loc  = tomb_seen_q ? tomb_q : pos_q;
        end else if (match) begin
          fin  = 1'b1;
          have = 1'b1;
          hit  = 1'b1;
          loc  = pos_q;
        end else if (cnt_q + 1'b1 >= eff_size) begin
          fin  = 1'b1;
          if (rd_data.mark == lphs_pkg::MarkTomb && !tomb_seen_q) begin
            have = 1'b1;
            loc  = pos_q;
          end else begin
            have = tomb_seen_q;
            loc  = tomb_q;
          end
        end
        if (!fin) begin
          if (rd_data.mark == lphs_pkg::MarkTomb && !tomb_seen_q) begin
            tomb_seen_d = 1'b1;
            tomb_d      = pos_q;
          end
          cnt_d   = cnt_q + 1'b1;
          pos_d   = pos_next;
          state_d = S_READ;
        end else if (!out_valid_q || !out_stall) begin
          // result register free: write back and present the word
          rsp_d                = '0;
          rsp_d.hit            = hit;
          unique case (req_q.kind)
            lphs_pkg::KindInsert: begin
              if (hit) begin
                rsp_d.status     = lphs_pkg::StPresent;
                rsp_d.slot_index = 10'(loc);
              end else if (have) begin
                wr.en           = 1'b1;
                wr.addr         = loc;
                wr.data.mark    = lphs_pkg::MarkFull;
                wr.data.key     = req_q.key;
                wr.data.payload = req_q.payload;
                occ_d            = occ_q + 1'b1;
                rsp_d.status     = lphs_pkg::StAdded;
                rsp_d.slot_index = 10'(loc);
              end else begin
                rsp_d.status = lphs_pkg::StFull;
              end
            end
            lphs_pkg::KindRemove: begin
              if (hit) begin
                wr.en        = 1'b1;
                wr.mark_only = 1'b1;
                wr.addr      = loc;
                wr.data.mark = lphs_pkg::MarkTomb;
                if (occ_q != '0) occ_d = occ_q - 1'b1;
                rsp_d.status     = lphs_pkg::StRemoved;
                rsp_d.slot_index = 10'(loc);
              end else begin
                rsp_d.status = lphs_pkg::StMissing;
              end
            end
            default: begin
              if (hit) begin
                rsp_d.status         = lphs_pkg::StFound;
                rsp_d.stored_payload = rd_data.payload;
                rsp_d.slot_index     = 10'(loc);
              end else begin
                rsp_d.status = lphs_pkg::StMissing;
              end
            end
          endcase
          rsp_d.element_total = occ_d;
          out_valid_d         = 1'b1;
          state_d             = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      tomb_seen_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      tomb_seen_q <= tomb_seen_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data;
    pos_q  <= pos_d;
    tomb_q <= tomb_d;
    rsp_q  <= rsp_d;
  end

endmodule

`default_nettype wire

// File: rtl/lphs_slot_store.sv
// ----------------------------------------------------------------------------
// lphs_slot_store
// slot memories: mark array with clearing pass, key and payload arrays
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_slot_store (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire logic [lphs_pkg::SlotBits-1:0] rd_addr_i,
  input  wire lphs_pkg::slot_wr_t            wr_i,
  output lphs_pkg::slot_t                    rd_data_o,
  output logic                               clr_busy_o
);

  logic [1:0]                       mark_mem [lphs_pkg::Capacity];
  logic [lphs_pkg::KeyBits-1:0]     key_mem  [lphs_pkg::Capacity];
  logic [lphs_pkg::PayloadBits-1:0] pay_mem  [lphs_pkg::Capacity];

  logic [lphs_pkg::SlotBits-1:0] clr_addr_q;
  logic                          clr_busy_q;

  // clearing pass over the mark memory after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == lphs_pkg::SlotBits'(lphs_pkg::Capacity - 1)) clr_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mark_mem[clr_addr_q] <= lphs_pkg::MarkEmpty;
    end else if (wr_i.en) begin
      mark_mem[wr_i.addr] <= wr_i.data.mark;
    end
    if (wr_i.en && !wr_i.mark_only) begin
      key_mem[wr_i.addr] <= wr_i.data.key;
      pay_mem[wr_i.addr] <= wr_i.data.payload;
    end
    rd_data_o.mark    <= mark_mem[rd_addr_i];
    rd_data_o.key     <= key_mem[rd_addr_i];
    rd_data_o.payload <= pay_mem[rd_addr_i];
  end

  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// File: rtl/lphs_hash_mod.sv
// ----------------------------------------------------------------------------
// lphs_hash_mod
// iterative restoring reduction of the hash modulo the table size
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_hash_mod (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire logic [lphs_pkg::HashBits-1:0] hash_i,
  input  wire logic [lphs_pkg::SizeBits-1:0] size_i,
  output logic                               done_o,
  output logic [lphs_pkg::SlotBits-1:0]      rem_o
);

  localparam int unsigned CntBits = $clog2(lphs_pkg::HashBits + 1);

  logic [lphs_pkg::HashBits-1:0] sh_q;
  logic [lphs_pkg::SizeBits:0]   rem_q;
  logic [CntBits-1:0]            cnt_q;
  logic                          busy_q;
  logic [lphs_pkg::SizeBits:0]   trial;

  assign trial = {rem_q[lphs_pkg::SizeBits-1:0], sh_q[lphs_pkg::HashBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(lphs_pkg::HashBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= hash_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q <= {sh_q[lphs_pkg::HashBits-2:0], 1'b0};
      if (trial >= {1'b0, size_i}) rem_q <= trial - {1'b0, size_i};
      else rem_q <= trial;
    end
  end

  assign rem_o = rem_q[lphs_pkg::SlotBits-1:0];

endmodule

`default_nettype wire
